FILE: rtl/overwriting_sample_ring_buffer_assert.svh
// ----------------------------------------------------------------------------
// Overwriting sample ring buffer assertion macros
// Shared macros for the concurrent checks of the ring buffer top level.
// ----------------------------------------------------------------------------
`ifndef OVERWRITING_SAMPLE_RING_BUFFER_ASSERT_SVH
`define OVERWRITING_SAMPLE_RING_BUFFER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OSRB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OSRB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/osrb_pkg.sv
// ----------------------------------------------------------------------------
// Overwriting sample ring buffer package
// Field widths, action codes, register map and controller/datapath interface.
// ----------------------------------------------------------------------------
package osrb_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COUNT_W     = 7;
  localparam int LEVEL_OUT_W = 11;
  localparam int TOTAL_W     = 32;
  localparam int ACTION_W    = 2;
  localparam int THR_W       = 11;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  localparam logic [THR_W-1:0] THR_RESET = 11'd256;

  // Register index as seen in paddr[2].
  localparam logic REG_THRESHOLD = 1'b0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write;
    logic read_start;
    logic underrun;
    logic clear;
    logic issue;
    logic issue_last;
  } osrb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [COUNT_W-1:0] read_len;
  } osrb_status_t;

endpackage

FILE: rtl/osrb_cfg.sv
// ----------------------------------------------------------------------------
// Ring buffer configuration register
// APB-style slave holding the packet threshold register.
// ----------------------------------------------------------------------------
module osrb_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [osrb_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [osrb_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [osrb_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic [osrb_pkg::THR_W-1:0]       threshold
);
  import osrb_pkg::*;

  logic wr_en;

  // The access phase never waits: pready is held high.
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // Threshold register; other addresses ignore writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (wr_en && paddr[2] == REG_THRESHOLD) begin
      threshold <= pwdata[THR_W-1:0];
    end
  end

  // Read back the register, zero elsewhere.
  assign prdata = (paddr[2] == REG_THRESHOLD) ? APB_DATA_W'(threshold) : '0;

endmodule

FILE: rtl/osrb_ctrl.sv
// ----------------------------------------------------------------------------
// Ring buffer controller
// Decodes accepted words and sequences the sample reads of a read request.
// ----------------------------------------------------------------------------
module osrb_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [osrb_pkg::ACTION_W-1:0]  action,
  input  logic [osrb_pkg::COUNT_W-1:0]   read_count,
  input  osrb_pkg::osrb_status_t         status,
  output osrb_pkg::osrb_cmd_t            cmd,
  output logic                           busy
);
  import osrb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [COUNT_W-1:0] remain;
  logic [COUNT_W-1:0] remain_next;

  assign busy = (state != ST_IDLE);

  // Next state and commands.
  always_comb begin
    cmd         = '0;
    state_next  = state;
    remain_next = remain;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (action_t'(action))
            ACT_WRITE: begin
              cmd.write = 1'b1;
            end
            ACT_READ: begin
              if (read_count != '0) begin
                if (status.read_len == '0) begin
                  cmd.underrun = 1'b1;
                end else begin
                  cmd.read_start = 1'b1;
                  remain_next    = status.read_len;
                  state_next     = ST_ISSUE;
                end
              end
            end
            ACT_CLEAR: begin
              cmd.clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ISSUE: begin
        cmd.issue      = 1'b1;
        cmd.issue_last = (remain == COUNT_W'(1));
        remain_next    = remain - COUNT_W'(1);
        if (remain == COUNT_W'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and sample counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      remain <= '0;
    end else begin
      state  <= state_next;
      remain <= remain_next;
    end
  end

endmodule

FILE: rtl/osrb_dp.sv
// ----------------------------------------------------------------------------
// Ring buffer datapath
// Sample memory, pointers, level, ready flag, counters and result register.
// ----------------------------------------------------------------------------
module osrb_dp #(
  parameter int RING_DEPTH = 1024,
  parameter int MAX_READ   = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  osrb_pkg::osrb_cmd_t                cmd,
  output osrb_pkg::osrb_status_t             status,
  input  logic signed [osrb_pkg::SAMPLE_W-1:0] sample_in,
  input  logic                               burst_last,
  input  logic [osrb_pkg::COUNT_W-1:0]       read_count,
  input  logic [osrb_pkg::THR_W-1:0]         threshold,
  output logic                               result_strobe,
  output logic signed [osrb_pkg::SAMPLE_W-1:0] sample_out,
  output logic                               sample_valid,
  output logic                               last,
  output logic [osrb_pkg::COUNT_W-1:0]       samples_read,
  output logic [osrb_pkg::LEVEL_OUT_W-1:0]   fill_level,
  output logic                               ready_flag,
  output logic [osrb_pkg::TOTAL_W-1:0]       overrun_total,
  output logic [osrb_pkg::TOTAL_W-1:0]       underrun_total
);
  import osrb_pkg::*;

  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int LVL_W = $clog2(RING_DEPTH + 1);

  logic signed [SAMPLE_W-1:0] mem [RING_DEPTH];
  logic signed [SAMPLE_W-1:0] rdata;
  logic                       rd_valid;
  logic                       rd_last;
  logic [COUNT_W-1:0]         nread;

  logic [IDX_W-1:0]   wr_idx, wr_idx_next, wr_idx_inc;
  logic [IDX_W-1:0]   rd_idx, rd_idx_next, rd_idx_inc;
  logic [LVL_W-1:0]   level, level_next;
  logic               ready, ready_next;
  logic [TOTAL_W-1:0] overruns, overruns_next;
  logic [TOTAL_W-1:0] underruns, underruns_next;

  logic [31:0]        level_ext;
  logic [31:0]        level_next_ext;
  logic [31:0]        thr_ext;
  logic               full;
  logic [COUNT_W-1:0] count_sat;
  logic [COUNT_W-1:0] read_len;
  logic [LVL_W-1:0]   wr_level;
  logic [LVL_W-1:0]   rd_level;

  // Pointer increments with wrap at the ring depth.
  assign wr_idx_inc = (wr_idx == IDX_W'(RING_DEPTH - 1)) ? '0 : wr_idx + IDX_W'(1);
  assign rd_idx_inc = (rd_idx == IDX_W'(RING_DEPTH - 1)) ? '0 : rd_idx + IDX_W'(1);

  // Level arithmetic and read length.
  assign level_ext = 32'(level);
  assign thr_ext   = 32'(threshold);
  assign full      = (level_ext == 32'(RING_DEPTH));
  assign count_sat = (read_count > COUNT_W'(MAX_READ)) ? COUNT_W'(MAX_READ) : read_count;
  assign read_len  = (level_ext < 32'(count_sat)) ? level_ext[COUNT_W-1:0] : count_sat;
  assign wr_level  = full ? level : level + LVL_W'(1);
  assign rd_level  = level - LVL_W'(read_len);
  assign status.read_len = read_len;

  // Next values of the ring state.
  always_comb begin
    wr_idx_next    = wr_idx;
    rd_idx_next    = rd_idx;
    level_next     = level;
    ready_next     = ready;
    overruns_next  = overruns;
    underruns_next = underruns;
    if (cmd.clear) begin
      wr_idx_next    = '0;
      rd_idx_next    = '0;
      level_next     = '0;
      ready_next     = 1'b0;
      overruns_next  = '0;
      underruns_next = '0;
    end
    if (cmd.write) begin
      wr_idx_next = wr_idx_inc;
      level_next  = wr_level;
      if (full) begin
        rd_idx_next   = rd_idx_inc;
        overruns_next = overruns + TOTAL_W'(1);
      end
      if (32'(wr_level) >= thr_ext) begin
        ready_next = 1'b1;
      end
    end
    if (cmd.underrun) begin
      underruns_next = underruns + TOTAL_W'(1);
    end
    if (cmd.read_start) begin
      level_next = rd_level;
      if (32'(rd_level) < thr_ext) begin
        ready_next = 1'b0;
      end
    end
    if (cmd.issue) begin
      rd_idx_next = rd_idx_inc;
    end
  end

  assign level_next_ext = 32'(level_next);

  // Ring state and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx        <= '0;
      rd_idx        <= '0;
      level         <= '0;
      ready         <= 1'b0;
      overruns      <= '0;
      underruns     <= '0;
      rd_valid      <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      wr_idx        <= wr_idx_next;
      rd_idx        <= rd_idx_next;
      level         <= level_next;
      ready         <= ready_next;
      overruns      <= overruns_next;
      underruns     <= underruns_next;
      rd_valid      <= cmd.issue;
      result_strobe <= (cmd.write & burst_last) | cmd.underrun | rd_valid;
    end
  end

  // Sample memory with registered read data.
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[wr_idx] <= sample_in;
    end
    if (cmd.issue) begin
      rdata <= mem[rd_idx];
    end
  end

  // Read tags and result word.
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_last <= cmd.issue_last;
    end
    if (cmd.read_start) begin
      nread <= read_len;
    end
    if (rd_valid) begin
      sample_out   <= rdata;
      sample_valid <= 1'b1;
      last         <= rd_last;
      samples_read <= nread;
    end else begin
      sample_out   <= '0;
      sample_valid <= 1'b0;
      last         <= 1'b1;
      samples_read <= '0;
    end
    fill_level     <= level_next_ext[LEVEL_OUT_W-1:0];
    ready_flag     <= ready_next;
    overrun_total  <= overruns_next;
    underrun_total <= underruns_next;
  end

endmodule

FILE: rtl/overwriting_sample_ring_buffer.sv
// ----------------------------------------------------------------------------
// Overwriting sample ring buffer
// Ring FIFO of 16-bit samples that drops the oldest sample when full.
//
// Channel   Direction  Handshake                     Word
// input     in         start high while busy low     action, sample_in,
//                                                    burst_last, read_count
// result    out        result_strobe, one cycle      sample_out .. underrun_total
// config    in/out     APB write, pready always high packet_threshold
//
// A write, clear or empty read leaves busy low.
// A write with burst_last or an empty read gives its result in the next cycle.
// A read holds busy in the issue state, one memory read a cycle through the
// single read port, then in the drain state for the read data register.
// Results follow at one per cycle; the receiver cannot stall them.
// Reset is synchronous and clears pointers, level, flag and counters.
// ----------------------------------------------------------------------------
module overwriting_sample_ring_buffer #(
  parameter int RING_DEPTH = 1024,
  parameter int MAX_READ   = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [osrb_pkg::ACTION_W-1:0]        action,
  input  logic signed [osrb_pkg::SAMPLE_W-1:0] sample_in,
  input  logic                                 burst_last,
  input  logic [osrb_pkg::COUNT_W-1:0]         read_count,
  output logic                                 result_strobe,
  output logic signed [osrb_pkg::SAMPLE_W-1:0] sample_out,
  output logic                                 sample_valid,
  output logic                                 last,
  output logic [osrb_pkg::COUNT_W-1:0]         samples_read,
  output logic [osrb_pkg::LEVEL_OUT_W-1:0]     fill_level,
  output logic                                 ready_flag,
  output logic [osrb_pkg::TOTAL_W-1:0]         overrun_total,
  output logic [osrb_pkg::TOTAL_W-1:0]         underrun_total,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [osrb_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [osrb_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [osrb_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import osrb_pkg::*;

`include "overwriting_sample_ring_buffer_assert.svh"

  osrb_cmd_t          cmd;
  osrb_status_t       status;
  logic [THR_W-1:0]   threshold;
  logic               accept;

  assign accept = start & ~busy;

  // Configuration register.
  osrb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .threshold (threshold)
  );

  // Controller.
  osrb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .action     (action),
    .read_count (read_count),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy)
  );

  // Datapath.
  osrb_dp #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_READ   (MAX_READ)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .sample_in      (sample_in),
    .burst_last     (burst_last),
    .read_count     (read_count),
    .threshold      (threshold),
    .result_strobe  (result_strobe),
    .sample_out     (sample_out),
    .sample_valid   (sample_valid),
    .last           (last),
    .samples_read   (samples_read),
    .fill_level     (fill_level),
    .ready_flag     (ready_flag),
    .overrun_total  (overrun_total),
    .underrun_total (underrun_total)
  );

  // A status word carries no sample and always closes its step.
  `OSRB_ASSERT_SAME(a_status_word, clk, rst,
    result_strobe && !sample_valid, last && sample_out == '0 && samples_read == '0,
    "status word with sample data or without last")

  // A write that does not close a burst gives no word.
  `OSRB_ASSERT_NEXT(a_write_silent, clk, rst,
    accept && action == ACT_WRITE && !burst_last, !result_strobe,
    "word after a write without burst_last")

  // A read request with a nonzero count either answers at once or starts reading.
  `OSRB_ASSERT_NEXT(a_read_starts, clk, rst,
    accept && action == ACT_READ && read_count != '0, result_strobe || busy,
    "read request neither answered nor started")

endmodule
